@@ rtl/shrb_pkg.sv @@
// Package: sizes, status codes, states and pointer helpers for the history ring.
`timescale 1ns / 1ps

package shrb_pkg;

    // Ring geometry
    localparam int CAPACITY     = 64;
    localparam int PAYLOAD_BITS = 32;
    localparam int PTR_W        = $clog2(CAPACITY);
    localparam int CNT_W        = $clog2(CAPACITY + 1);

    // Fixed field widths of the channels
    localparam int SEQ_W   = 32;
    localparam int PAY_W   = 32;
    localparam int REQ_W   = 7;
    localparam int STAT_W  = 2;
    localparam int FIELD_CNT_W = 7;
    localparam int CMP_W   = (CNT_W > REQ_W) ? CNT_W : REQ_W;

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // Command codes
    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_COPY   = 1'b1;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_APPENDED  = 2'd0,
        STAT_COPIED    = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_NONE      = 2'd3
    } status_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OLD_RD,
        ST_OLD_CAP,
        ST_REPLY,
        ST_SCAN,
        ST_EMIT
    } state_t;

    // One result item
    typedef struct packed {
        status_t                status;
        logic [SEQ_W-1:0]       out_sequence;
        logic [PAY_W-1:0]       out_payload;
        logic                   last;
        logic [FIELD_CNT_W-1:0] stored_count;
        logic [SEQ_W-1:0]       oldest_sequence;
        logic [FIELD_CNT_W-1:0] emit_total;
    } result_t;

    // Advance a ring pointer with wrap
    function automatic ptr_t ptr_inc(input ptr_t p);
        ptr_t r;
        if (p == PTR_W'(CAPACITY - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    // Sum of two ring positions modulo the capacity (both below it)
    function automatic ptr_t ptr_add(input ptr_t a, input ptr_t b);
        logic [PTR_W:0] s;
        ptr_t           r;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (PTR_W + 1)'(CAPACITY))
        begin
            r = PTR_W'(s - (PTR_W + 1)'(CAPACITY));
        end
        else
        begin
            r = PTR_W'(s);
        end
        return r;
    endfunction

endpackage

@@ rtl/shrb_cmd_if.sv @@
// Interface: command channel (append or copy request).
`timescale 1ns / 1ps

interface shrb_cmd_if
    import shrb_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic                   command;
    logic [SEQ_W-1:0]       record_sequence;
    logic [PAY_W-1:0]       record_payload;
    logic [SEQ_W-1:0]       lookup_sequence;
    logic [REQ_W-1:0]       max_records;

    modport source (
        output valid, command, record_sequence, record_payload,
               lookup_sequence, max_records,
        input  ready
    );

    modport sink (
        input  valid, command, record_sequence, record_payload,
               lookup_sequence, max_records,
        output ready
    );
endinterface

@@ rtl/shrb_res_if.sv @@
// Interface: result channel (status and copied records).
`timescale 1ns / 1ps

interface shrb_res_if
    import shrb_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [STAT_W-1:0]      status;
    logic [SEQ_W-1:0]       out_sequence;
    logic [PAY_W-1:0]       out_payload;
    logic                   last;
    logic [FIELD_CNT_W-1:0] stored_count;
    logic [SEQ_W-1:0]       oldest_sequence;
    logic [FIELD_CNT_W-1:0] emit_total;

    modport source (
        output valid, status, out_sequence, out_payload, last, stored_count,
               oldest_sequence, emit_total,
        input  ready
    );

    modport sink (
        input  valid, status, out_sequence, out_payload, last, stored_count,
               oldest_sequence, emit_total,
        output ready
    );
endinterface

@@ rtl/sequenced_history_ring_buffer.sv @@
// History ring of CAPACITY records with sequence lookup and run copy.
// Append: result registered in ST_REPLY; when full, ST_OLD_RD/CAP first read the new oldest.
// Copy: one sequence compared per cycle until the start is found or every held one is missed;
//   a miss or zero request replies via ST_REPLY; records one per cycle unless res stalls.
// One item at a time; the next item is taken once all its results are queued.
// rst_n clears pointer, count, oldest sequence and control; memories are not cleared.
`timescale 1ns / 1ps

module sequenced_history_ring_buffer
    import shrb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    shrb_cmd_if.sink    cmd,
    shrb_res_if.source  res
);

    // Record memories
    logic [SEQ_W-1:0]        seq_mem [CAPACITY];
    logic [PAYLOAD_BITS-1:0] pay_mem [CAPACITY];
    logic [SEQ_W-1:0]        rd_seq_reg;
    logic [PAYLOAD_BITS-1:0] rd_pay_reg;
    logic                    mem_we;
    logic                    rd_en;

    // Control and ring state
    state_t            state_reg,    state_next;
    ptr_t              wp_reg,       wp_next;
    cnt_t              held_reg,     held_next;
    logic [SEQ_W-1:0]  oldest_reg,   oldest_next;
    ptr_t              rd_ptr_reg,   rd_ptr_next;
    cnt_t              scan_off_reg, scan_off_next;
    logic              cmp_vld_reg,  cmp_vld_next;
    cnt_t              cmp_off_reg,  cmp_off_next;
    logic [SEQ_W-1:0]  start_reg,    start_next;
    logic [REQ_W-1:0]  req_reg,      req_next;
    cnt_t              n_reg,        n_next;
    cnt_t              emit_i_reg,   emit_i_next;
    logic              data_vld_reg, data_vld_next;
    status_t           reply_reg,    reply_next;
    logic              out_vld_reg,  out_vld_next;
    result_t           res_reg,      res_next;

    logic              accept;
    logic              out_free;
    logic              full;
    ptr_t              first;
    cnt_t              avail;
    logic [CMP_W-1:0]  req_w;
    logic [CMP_W-1:0]  avail_w;
    cnt_t              n_calc;

    assign accept   = cmd.valid && cmd.ready;
    assign out_free = !out_vld_reg || res.ready;
    assign full     = (held_reg == CNT_W'(CAPACITY));
    // Oldest slot is 0 until the ring fills, then the write pointer
    assign first    = full ? wp_reg : '0;

    // Records available from the match to the newest, capped by the request
    assign avail    = held_reg - cmp_off_reg;
    assign req_w    = CMP_W'(req_reg);
    assign avail_w  = CMP_W'(avail);
    assign n_calc   = (req_w < avail_w) ? CNT_W'(req_reg) : avail;

    // Memory write and registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            seq_mem[wp_reg] <= cmd.record_sequence;
            pay_mem[wp_reg] <= PAYLOAD_BITS'(cmd.record_payload);
        end
        if (rd_en)
        begin
            rd_seq_reg <= seq_mem[rd_ptr_reg];
            rd_pay_reg <= pay_mem[rd_ptr_reg];
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            wp_reg       <= '0;
            held_reg     <= '0;
            oldest_reg   <= '0;
            cmp_vld_reg  <= 1'b0;
            data_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            wp_reg       <= wp_next;
            held_reg     <= held_next;
            oldest_reg   <= oldest_next;
            cmp_vld_reg  <= cmp_vld_next;
            data_vld_reg <= data_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        rd_ptr_reg   <= rd_ptr_next;
        scan_off_reg <= scan_off_next;
        cmp_off_reg  <= cmp_off_next;
        start_reg    <= start_next;
        req_reg      <= req_next;
        n_reg        <= n_next;
        emit_i_reg   <= emit_i_next;
        reply_reg    <= reply_next;
        res_reg      <= res_next;
    end

    // Next state and outputs
    always_comb
    begin
        state_next    = state_reg;
        wp_next       = wp_reg;
        held_next     = held_reg;
        oldest_next   = oldest_reg;
        rd_ptr_next   = rd_ptr_reg;
        scan_off_next = scan_off_reg;
        cmp_vld_next  = cmp_vld_reg;
        cmp_off_next  = cmp_off_reg;
        start_next    = start_reg;
        req_next      = req_reg;
        n_next        = n_reg;
        emit_i_next   = emit_i_reg;
        data_vld_next = data_vld_reg;
        reply_next    = reply_reg;
        res_next      = res_reg;
        out_vld_next  = out_vld_reg && !res.ready;
        mem_we        = 1'b0;
        rd_en         = 1'b0;
        cmd.ready     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.ready = 1'b1;
                if (accept)
                begin
                    if (cmd.command == CMD_APPEND)
                    begin
                        mem_we     = 1'b1;
                        wp_next    = ptr_inc(wp_reg);
                        reply_next = STAT_APPENDED;
                        if (held_reg == '0)
                        begin
                            oldest_next = cmd.record_sequence;
                        end
                        if (full)
                        begin
                            // oldest record was overwritten: fetch the new oldest
                            rd_ptr_next = ptr_inc(wp_reg);
                            state_next  = ST_OLD_RD;
                        end
                        else
                        begin
                            held_next  = held_reg + 1'b1;
                            state_next = ST_REPLY;
                        end
                    end
                    else
                    begin
                        start_next    = cmd.lookup_sequence;
                        req_next      = cmd.max_records;
                        scan_off_next = '0;
                        cmp_vld_next  = 1'b0;
                        rd_ptr_next   = first;
                        state_next    = ST_SCAN;
                    end
                end
            end

            ST_OLD_RD:
            begin
                rd_en      = 1'b1;
                state_next = ST_OLD_CAP;
            end

            ST_OLD_CAP:
            begin
                oldest_next = rd_seq_reg;
                state_next  = ST_REPLY;
            end

            ST_REPLY:
            begin
                // single status result
                if (out_free)
                begin
                    res_next.status          = reply_reg;
                    res_next.out_sequence    = '0;
                    res_next.out_payload     = '0;
                    res_next.last            = 1'b1;
                    res_next.stored_count    = FIELD_CNT_W'(held_reg);
                    res_next.oldest_sequence = oldest_reg;
                    res_next.emit_total      = '0;
                    out_vld_next             = 1'b1;
                    state_next               = ST_IDLE;
                end
            end

            ST_SCAN:
            begin
                // one read issued and one compare per cycle, oldest first
                if (cmp_vld_reg && (rd_seq_reg == start_reg))
                begin
                    cmp_vld_next = 1'b0;
                    if (n_calc == '0)
                    begin
                        reply_next = STAT_NONE;
                        state_next = ST_REPLY;
                    end
                    else
                    begin
                        n_next        = n_calc;
                        rd_ptr_next   = ptr_add(first, cmp_off_reg[PTR_W-1:0]);
                        emit_i_next   = '0;
                        data_vld_next = 1'b0;
                        state_next    = ST_EMIT;
                    end
                end
                else if (scan_off_reg == held_reg)
                begin
                    cmp_vld_next = 1'b0;
                    reply_next   = STAT_NOT_FOUND;
                    state_next   = ST_REPLY;
                end
                else
                begin
                    rd_en         = 1'b1;
                    rd_ptr_next   = ptr_inc(rd_ptr_reg);
                    cmp_vld_next  = 1'b1;
                    cmp_off_next  = scan_off_reg;
                    scan_off_next = scan_off_reg + 1'b1;
                end
            end

            ST_EMIT:
            begin
                // read ahead one record while the current one goes out
                if (!data_vld_reg)
                begin
                    rd_en         = 1'b1;
                    rd_ptr_next   = ptr_inc(rd_ptr_reg);
                    data_vld_next = 1'b1;
                end
                else if (out_free)
                begin
                    res_next.status          = STAT_COPIED;
                    res_next.out_sequence    = rd_seq_reg;
                    res_next.out_payload     = PAY_W'(rd_pay_reg);
                    res_next.last            = (CNT_W'(emit_i_reg + 1'b1) == n_reg);
                    res_next.stored_count    = FIELD_CNT_W'(held_reg);
                    res_next.oldest_sequence = oldest_reg;
                    res_next.emit_total      = FIELD_CNT_W'(n_reg);
                    out_vld_next             = 1'b1;
                    if (CNT_W'(emit_i_reg + 1'b1) == n_reg)
                    begin
                        data_vld_next = 1'b0;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        emit_i_next = emit_i_reg + 1'b1;
                        rd_en       = 1'b1;
                        rd_ptr_next = ptr_inc(rd_ptr_reg);
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result channel
    assign res.valid           = out_vld_reg;
    assign res.status          = res_reg.status;
    assign res.out_sequence    = res_reg.out_sequence;
    assign res.out_payload     = res_reg.out_payload;
    assign res.last            = res_reg.last;
    assign res.stored_count    = res_reg.stored_count;
    assign res.oldest_sequence = res_reg.oldest_sequence;
    assign res.emit_total      = res_reg.emit_total;

endmodule
